>>> design/pwct_pkg.sv
package pwct_pkg;

  localparam int CodeBits    = 25;
  localparam int WidthW      = 8;
  localparam int PhaseW      = 9;
  localparam int GapW        = 16;
  localparam int SymIdxW     = 5;
  localparam int SymbolsDef  = 25;

  localparam int ApbAddrW    = 4;
  localparam int ApbDataW    = 32;

  localparam logic [CodeBits-1:0] CodeWordRst   = CodeBits'(10671810);
  localparam logic [WidthW-1:0]   ShortWidthRst = WidthW'(1);
  localparam logic [WidthW-1:0]   LongWidthRst  = WidthW'(3);
  localparam logic [GapW-1:0]     GapTicksRst   = GapW'(150);

  typedef enum logic [1:0] {
    RegCodeWord   = 2'd0,
    RegShortWidth = 2'd1,
    RegLongWidth  = 2'd2,
    RegGapTicks   = 2'd3
  } reg_idx_e;

  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] w);
    eff_width = (w == '0) ? WidthW'(1) : w;
  endfunction

endpackage

>>> design/pulse_width_code_transmitter.sv
// Pulse-width code transmitter.
// Each request on the input channel (in_valid_i / in_stall_o) carries one
// tick_i bit; a 1 advances the transmitter by one time tick, a 0 only reports
// the current state. Every request yields exactly one result on the output
// channel (out_valid_o / out_stall_i): the line level after the tick, the
// number of symbols completed in the frame (SYMBOLS during the inter-frame
// gap) and a frame_start flag on the tick where the gap ends.
// The result register holds the result of a request accepted at the previous
// edge. One request is taken per cycle while the result is not stalled; the
// tick logic is a single pass of counters and compares into that register.
// When the receiver stalls while a result is held, in_stall_o is raised and
// the held result and all transmitter state stay unchanged until it is taken.
// Reset loads the default code word and timing registers, sets the line high
// with symbol count zero and clears the result valid flag. The first frame
// after reset spends symbol 0 in a long low phase.
// Program the APB registers only while no request is in flight: code_word at
// 0x0, short_width at 0x4, long_width at 0x8, gap_ticks at 0xC.
module pulse_width_code_transmitter
  import pwct_pkg::*;
#(
  parameter int SYMBOLS = SymbolsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,

  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                tick_i,

  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                line_level_o,
  output logic [SymIdxW-1:0]  symbol_index_o,
  output logic                frame_start_o
);

  localparam int SymCntW = $clog2(SYMBOLS + 1);
  localparam logic [SymCntW-1:0] SymLast = SymCntW'(SYMBOLS);

  logic [CodeBits-1:0] code_word_q;
  logic [WidthW-1:0]   short_width_q;
  logic [WidthW-1:0]   long_width_q;
  logic [GapW-1:0]     gap_ticks_q;

  logic                level_q, level_d;
  logic [WidthW-1:0]   plen_q, plen_d;
  logic [PhaseW-1:0]   pticks_q, pticks_d;
  logic [SymCntW-1:0]  sym_q, sym_d;
  logic [GapW-1:0]     gap_q, gap_d;
  logic                fstart_d;

  logic                out_valid_q;
  logic                line_level_q;
  logic [SymIdxW-1:0]  symbol_index_q;
  logic                frame_start_q;

  logic                accept;
  logic                cfg_wr;
  logic [WidthW-1:0]   sw, lw;
  logic [PhaseW-1:0]   pt_inc;
  logic [CodeBits-1:0] code_shift;
  logic                sym_bit;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    unique case (reg_idx_e'(paddr[3:2]))
      RegCodeWord:   prdata = ApbDataW'(code_word_q);
      RegShortWidth: prdata = ApbDataW'(short_width_q);
      RegLongWidth:  prdata = ApbDataW'(long_width_q);
      RegGapTicks:   prdata = ApbDataW'(gap_ticks_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_word_q   <= CodeWordRst;
      short_width_q <= ShortWidthRst;
      long_width_q  <= LongWidthRst;
      gap_ticks_q   <= GapTicksRst;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3:2]))
        RegCodeWord:   code_word_q   <= pwdata[CodeBits-1:0];
        RegShortWidth: short_width_q <= pwdata[WidthW-1:0];
        RegLongWidth:  long_width_q  <= pwdata[WidthW-1:0];
        RegGapTicks:   gap_ticks_q   <= pwdata[GapW-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign sw         = eff_width(short_width_q);
  assign lw         = eff_width(long_width_q);
  assign pt_inc     = pticks_q + PhaseW'(1);
  assign code_shift = code_word_q >> sym_q;
  assign sym_bit    = code_shift[0];

  always_comb begin
    level_d  = level_q;
    plen_d   = plen_q;
    pticks_d = pticks_q;
    sym_d    = sym_q;
    gap_d    = gap_q;
    fstart_d = 1'b0;
    if (tick_i) begin
      if (sym_q < SymLast) begin
        pticks_d = pt_inc;
        if (pticks_q >= {1'b0, plen_q}) begin
          if (level_q) begin
            plen_d  = (plen_q == lw) ? sw : lw;
            level_d = 1'b0;
          end else begin
            plen_d  = sym_bit ? lw : sw;
            level_d = 1'b1;
          end
          pticks_d = PhaseW'(1);
        end
        if (!level_d && (pticks_d == {1'b0, plen_d})) begin
          sym_d = sym_q + SymCntW'(1);
        end
      end else begin
        gap_d = gap_q + GapW'(1);
        if (gap_q >= gap_ticks_q) begin
          pticks_d = PhaseW'(1);
          sym_d    = '0;
          plen_d   = '0;
          level_d  = 1'b0;
          gap_d    = '0;
          fstart_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= 1'b1;
      plen_q      <= '0;
      pticks_q    <= '0;
      sym_q       <= '0;
      gap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        level_q  <= level_d;
        plen_q   <= plen_d;
        pticks_q <= pticks_d;
        sym_q    <= sym_d;
        gap_q    <= gap_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_level_q   <= level_d;
      symbol_index_q <= SymIdxW'(sym_d);
      frame_start_q  <= fstart_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign line_level_o   = line_level_q;
  assign symbol_index_o = symbol_index_q;
  assign frame_start_o  = frame_start_q;

`ifndef NO_ASSERTIONS
  a_sym_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_q <= SymLast)
    else $error("symbol count past frame length");

  a_gap_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sym_q == SymLast) |-> !level_q)
    else $error("line high during gap");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_start_o) |-> (symbol_index_o == '0 && !line_level_o))
    else $error("frame start with nonzero count or high line");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !tick_i) |=> ($stable(sym_q) && $stable(level_q) && $stable(gap_q)
                              && $stable(pticks_q) && !frame_start_o))
    else $error("state moved without a tick");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> (out_valid_o && $stable(sym_q) && $stable(level_q)))
    else $error("result or state lost under stall");
`endif

endmodule
